>>> hw/rtl/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants for the nearest point table.
// ----------------------------------------------------------------------------
package npt_pkg;

  localparam int COORD_W = 16;
  localparam int SQ_W    = 32;   // one squared coordinate difference
  localparam int DIST_W  = 33;   // sum of two squares
  localparam int INDEX_W = 8;    // width of the reported indexes

  localparam logic [15:0] RADIUS_RESET = 16'd12;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // status of the distance pipeline as seen by the sequencer
  typedef struct packed {
    logic busy;   // an entry is still in the early stages
    logic valid;  // a finished distance is presented this cycle
  } dist_stat_t;

endpackage

>>> hw/rtl/npt_store.sv
// ----------------------------------------------------------------------------
// npt_store
// Point memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npt_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [2*npt_pkg::COORD_W-1:0]  wdata,
  input  logic                           re,
  input  logic [AW-1:0]                  raddr,
  output logic [2*npt_pkg::COORD_W-1:0]  rdata
);

  logic [2*npt_pkg::COORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/npt_dist.sv
// ----------------------------------------------------------------------------
// npt_dist
// Shared squared distance unit: difference, square, sum over three stages.
// ----------------------------------------------------------------------------
module npt_dist #(
  parameter int AW = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [AW-1:0]                       in_idx,
  input  logic signed [npt_pkg::COORD_W-1:0]  qx,
  input  logic signed [npt_pkg::COORD_W-1:0]  qy,
  input  logic signed [npt_pkg::COORD_W-1:0]  px,
  input  logic signed [npt_pkg::COORD_W-1:0]  py,
  output npt_pkg::dist_stat_t                 stat,
  output logic [AW-1:0]                       out_idx,
  output logic [npt_pkg::DIST_W-1:0]          dist_sq
);

  logic                               s1_v, s2_v, s3_v;
  logic [AW-1:0]                      s1_idx, s2_idx;
  logic signed [npt_pkg::COORD_W:0]   dx, dy;
  logic signed [npt_pkg::COORD_W:0]   dx_q, dy_q;
  logic signed [2*npt_pkg::COORD_W+1:0] prod_x, prod_y;
  logic [npt_pkg::SQ_W-1:0]           sq_x, sq_y;

  assign dx = {qx[npt_pkg::COORD_W-1], qx} - {px[npt_pkg::COORD_W-1], px};
  assign dy = {qy[npt_pkg::COORD_W-1], qy} - {py[npt_pkg::COORD_W-1], py};

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
    s1_idx  <= in_idx;
    dx_q    <= dx;
    dy_q    <= dy;
    s2_idx  <= s1_idx;
    // a square of a 17-bit difference stays below 2^32
    sq_x    <= prod_x[npt_pkg::SQ_W-1:0];
    sq_y    <= prod_y[npt_pkg::SQ_W-1:0];
    out_idx <= s2_idx;
    dist_sq <= {1'b0, sq_x} + {1'b0, sq_y};
  end

  assign stat.busy  = s1_v | s2_v;
  assign stat.valid = s3_v;

endmodule

>>> hw/rtl/nearest_point_table_core.sv
// ----------------------------------------------------------------------------
// nearest_point_table_core
// Table of 2-D points with linear nearest and hit-radius search.
// ----------------------------------------------------------------------------
// An insert transaction appends its point (or flags it rejected when
// MAX_POINTS points are already held). A query transaction reads the
// stored points one a cycle through the single read port of the point memory
// and feeds them to a three-stage squared distance unit; a query on an empty
// table skips the scan. The input side is not ready while an item is in
// progress; a finished result waits in the output register and the next item
// may be taken meanwhile. hit_radius may be written at any time the block is
// idle and resets to 12.
module nearest_point_table_core #(
  parameter int MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] point_x,
  input  logic [15:0] point_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        insert_rejected,
  output logic        nearest_found,
  output logic [7:0]  nearest_index,
  output logic        hit_found,
  output logic [7:0]  hit_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, DONE} state_t;

  state_t                      state;
  logic [CW-1:0]               count;
  logic [AW-1:0]               rd_addr;
  logic                        rd_v;
  logic [AW-1:0]               rd_idx;
  logic [15:0]                 hit_radius;
  logic [15:0]                 qx, qy;
  logic [31:0]                 r2;
  logic [npt_pkg::DIST_W-1:0]  best;
  logic                        res_rej, res_nfound, res_hfound;
  logic [AW-1:0]               res_nidx, res_hidx;

  logic                        in_xfer, full, we, re;
  logic [31:0]                 rdata;
  npt_pkg::dist_stat_t         dstat;
  logic [AW-1:0]               d_idx;
  logic [npt_pkg::DIST_W-1:0]  d_dist;

  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid & in_ready;
  assign full      = (count == CW'(MAX_POINTS));
  assign we        = in_xfer & (kind == npt_pkg::KIND_INSERT) & ~full;
  assign re        = (state == SCAN);

  npt_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata ({point_x, point_y}),
    .re    (re),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  npt_dist #(
    .AW (AW)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_v),
    .in_idx   (rd_idx),
    .qx       (qx),
    .qy       (qy),
    .px       (rdata[31:16]),
    .py       (rdata[15:0]),
    .stat     (dstat),
    .out_idx  (d_idx),
    .dist_sq  (d_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      rd_v       <= 1'b0;
      out_valid  <= 1'b0;
      hit_radius <= npt_pkg::RADIUS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hit_radius <= cfg_data;
      end
      rd_v <= re;
      if (state == DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_xfer) begin
            if (kind == npt_pkg::KIND_QUERY) begin
              state <= (count == '0) ? DONE : SCAN;
            end else begin
              state <= DONE;
              if (!full) begin
                count <= count + CW'(1);
              end
            end
          end
        end
        SCAN: begin
          if (CW'(rd_addr) == count - CW'(1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!rd_v && !dstat.busy && !dstat.valid) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end

    // search datapath
    rd_idx <= rd_addr;
    if (state == SCAN) begin
      rd_addr <= rd_addr + AW'(1);
    end
    if (in_xfer) begin
      qx         <= point_x;
      qy         <= point_y;
      r2         <= {16'd0, hit_radius} * {16'd0, hit_radius};
      rd_addr    <= '0;
      res_rej    <= (kind == npt_pkg::KIND_INSERT) & full;
      res_nfound <= 1'b0;
      res_hfound <= 1'b0;
      res_nidx   <= '0;
      res_hidx   <= '0;
    end
    if (dstat.valid) begin
      if (!res_nfound || d_dist < best) begin
        res_nfound <= 1'b1;
        best       <= d_dist;
        res_nidx   <= d_idx;
      end
      if (!res_hfound && d_dist < {1'b0, r2}) begin
        res_hfound <= 1'b1;
        res_hidx   <= d_idx;
      end
    end

    // output register
    if (state == DONE && (!out_valid || out_ready)) begin
      insert_rejected <= res_rej;
      nearest_found   <= res_nfound;
      nearest_index   <= npt_pkg::INDEX_W'(res_nidx);
      hit_found       <= res_hfound;
      hit_index       <= npt_pkg::INDEX_W'(res_hidx);
    end
  end

endmodule

>>> hw/rtl/npt_checker.sv
// ----------------------------------------------------------------------------
// npt_checker
// Port-level checks for the nearest point table, bound to the top level.
// ----------------------------------------------------------------------------
module npt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       insert_rejected,
  input logic       nearest_found,
  input logic [7:0] nearest_index,
  input logic       hit_found,
  input logic [7:0] hit_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(nearest_index) && $stable(hit_index))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a rejected insert carries no search answer
  a_insert_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && insert_rejected |-> !nearest_found && !hit_found)
    else $error("rejected insert with search flags");

  // any hit means some point was seen
  a_hit_implies_nearest: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_found |-> nearest_found)
    else $error("hit without nearest");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_found |-> hit_index == 8'd0)
    else $error("hit index set without hit");

endmodule

bind nearest_point_table_core npt_checker u_npt_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .insert_rejected (insert_rejected),
  .nearest_found   (nearest_found),
  .nearest_index   (nearest_index),
  .hit_found       (hit_found),
  .hit_index       (hit_index)
);

>>> tb/tb_nearest_point_table_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_point_table_core
// Self-checking bench for the nearest point table.
// ----------------------------------------------------------------------------
// A short table of directed inserts and queries (empty table, coordinate
// extremes, duplicate points, the radius boundary) is followed by phases of
// random traffic, each under its own hit radius. The random part fills the
// table until inserts are turned away and aims most queries at or near stored
// points so that hits, ties and misses all occur. A local model of the table
// predicts each result a directed row does not give; all are compared in
// order with what the block returns. The sender runs in bursts and the
// receiver stalls in changing patterns, with one long hold-off backing it up.
// ----------------------------------------------------------------------------
module tb_nearest_point_table_core;

  localparam int TABLE_DEPTH     = 256;
  localparam int PHASE_COUNT     = 7;
  localparam int ITEMS_PER_PHASE = 162;
  localparam int SQUEEZE_PHASE   = 3;
  localparam int SQUEEZE_ITEM    = 40;
  localparam int SQUEEZE_CYCLES  = 1500;
  localparam int DRAIN_CYCLES    = TABLE_DEPTH + 20;
  localparam int CYCLE_LIMIT     = 1500000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic       rejected;
    logic       near_ok;
    logic [7:0] near_idx;
    logic       hit_ok;
    logic [7:0] hit_idx;
  } answer_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic        typed;
    answer_t     answer;
  } drill_row_t;

  typedef enum int {
    SINK_STEADY,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PERIODIC
  } sink_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        out_valid;
  logic        out_ready;
  logic        insert_rejected;
  logic        nearest_found;
  logic [7:0]  nearest_index;
  logic        hit_found;
  logic [7:0]  hit_index;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // expectation carried along with the payload for the directed rows
  logic    row_typed;
  answer_t row_answer;

  // local copy of the table and the radius
  logic [15:0] tbl_x [TABLE_DEPTH];
  logic [15:0] tbl_y [TABLE_DEPTH];
  int          fill;
  logic [15:0] radius;

  answer_t     pending_answers [$];
  drill_row_t  drill_rows [$];
  int          mismatch_count;
  int          cycle_count;
  bit          squeeze_req;
  bit          squeeze_done;

  nearest_point_table_core #(
    .MAX_POINTS(TABLE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .point_x        (point_x),
    .point_y        (point_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .insert_rejected(insert_rejected),
    .nearest_found  (nearest_found),
    .nearest_index  (nearest_index),
    .hit_found      (hit_found),
    .hit_index      (hit_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // applies one item to the table copy and returns what the block should say
  function automatic answer_t table_answer(logic k, logic [15:0] qx, logic [15:0] qy);
    answer_t a;
    longint  dx;
    longint  dy;
    longint  d;
    longint  best;
    longint  r2;
    a = '0;
    best = 0;
    if (k == npt_pkg::KIND_INSERT) begin
      if (fill >= TABLE_DEPTH) begin
        a.rejected = 1'b1;
      end else begin
        tbl_x[fill] = qx;
        tbl_y[fill] = qy;
        fill++;
      end
    end else begin
      r2 = longint'(radius) * longint'(radius);
      for (int i = 0; i < fill; i++) begin
        dx = longint'($signed(qx)) - longint'($signed(tbl_x[i]));
        dy = longint'($signed(qy)) - longint'($signed(tbl_y[i]));
        d = dx * dx + dy * dy;
        if (!a.near_ok || d < best) begin
          a.near_ok = 1'b1;
          a.near_idx = i[7:0];
          best = d;
        end
        if (!a.hit_ok && d < r2) begin
          a.hit_ok = 1'b1;
          a.hit_idx = i[7:0];
        end
      end
    end
    return a;
  endfunction

  function automatic logic [15:0] clamp_coord(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic add_row(logic k, logic [15:0] x, logic [15:0] y, logic typed, answer_t a);
    drill_row_t r;
    r.kind = k;
    r.x = x;
    r.y = y;
    r.typed = typed;
    r.answer = a;
    drill_rows.push_back(r);
  endtask

  task automatic drive_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(logic k, logic [15:0] x, logic [15:0] y, logic typed, answer_t a);
    @(negedge clk);
    in_valid   <= 1'b1;
    kind       <= k;
    point_x    <= x;
    point_y    <= y;
    row_typed  <= typed;
    row_answer <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    drive_gap(1);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_radius(logic [15:0] v);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly clustered points, duplicates and aimed queries, some fully random
  task automatic pick_item(int cx, int cy, output logic k, output logic [15:0] x,
                           output logic [15:0] y);
    int pick;
    int sel;
    int span;
    int ins_pct;
    ins_pct = (fill < TABLE_DEPTH) ? 60 : 20;
    k = ($urandom_range(99, 0) < ins_pct) ? npt_pkg::KIND_INSERT : npt_pkg::KIND_QUERY;
    pick = $urandom_range(9, 0);
    sel = (fill > 0) ? $urandom_range(fill - 1, 0) : 0;
    span = (radius < 200) ? int'(radius) + 2 : 200;
    x = $urandom_range(65535, 0);
    y = $urandom_range(65535, 0);
    if (k == npt_pkg::KIND_INSERT) begin
      if (pick < 5) begin
        x = clamp_coord(cx + $urandom_range(128, 0) - 64);
        y = clamp_coord(cy + $urandom_range(128, 0) - 64);
      end else if (pick < 7 && fill > 0) begin
        x = tbl_x[sel];
        y = tbl_y[sel];
      end
    end else begin
      if (pick < 5 && fill > 0) begin
        x = clamp_coord(int'($signed(tbl_x[sel])) + $urandom_range(2 * span, 0) - span);
        y = clamp_coord(int'($signed(tbl_y[sel])) + $urandom_range(2 * span, 0) - span);
      end else if (pick < 7 && fill > 0) begin
        x = tbl_x[sel];
        y = tbl_y[sel];
      end else if (pick == 7) begin
        x = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
        y = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_nearest_point_table_core: done, errors");
      $finish;
    end
  end

  // prediction on accepted items, in-order compare on accepted results
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) radius = cfg_data;
      if (in_valid && in_ready) begin
        want = table_answer(kind, point_x, point_y);
        pending_answers.push_back(row_typed ? row_answer : want);
      end
      if (out_valid && out_ready) begin
        got = {insert_rejected, nearest_found, nearest_index, hit_found, hit_index};
        if (pending_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: rej=%0d nf=%0d ni=%0d hf=%0d hi=%0d",
                     got.rejected, got.near_ok, got.near_idx, got.hit_ok, got.hit_idx);
        end else begin
          want = pending_answers.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("mismatch: want rej=%0d nf=%0d ni=%0d hf=%0d hi=%0d",
                       want.rejected, want.near_ok, want.near_idx, want.hit_ok,
                       want.hit_idx);
              $display("          got  rej=%0d nf=%0d ni=%0d hf=%0d hi=%0d",
                       got.rejected, got.near_ok, got.near_idx, got.hit_ok, got.hit_idx);
            end
          end
        end
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : sink
    sink_mode_t mode;
    int         left;
    int         tick;
    out_ready = 1'b0;
    mode = SINK_STEADY;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        for (int c = 0; c < SQUEEZE_CYCLES; c++) @(negedge clk);
        squeeze_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = sink_mode_t'($urandom_range(3, 0));
          left = $urandom_range(120, 20);
        end
        left--;
        case (mode)
          SINK_STEADY: out_ready <= 1'b1;
          SINK_COIN:   out_ready <= $urandom_range(1, 0);
          SINK_MOSTLY: out_ready <= ($urandom_range(9, 0) != 0);
          default:     out_ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [15:0] phase_radius [PHASE_COUNT];
    logic        k;
    logic [15:0] x;
    logic [15:0] y;
    int          burst_left;
    int          cx;
    int          cy;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = npt_pkg::KIND_INSERT;
    point_x = '0;
    point_y = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_answer = '0;
    fill = 0;
    radius = npt_pkg::RADIUS_RESET;
    mismatch_count = 0;
    cycle_count = 0;
    squeeze_req = 1'b0;
    squeeze_done = 1'b0;
    burst_left = 0;

    phase_radius[0] = npt_pkg::RADIUS_RESET;  // phase 0 runs on the reset value
    phase_radius[1] = 16'd0;
    phase_radius[2] = 16'hFFFF;
    phase_radius[3] = 16'd1;
    phase_radius[4] = $urandom_range(65535, 0);
    phase_radius[5] = 16'd300;
    phase_radius[6] = $urandom_range(2000, 2);

    // query on the empty table, corner points, a duplicate, radius boundary
    add_row(npt_pkg::KIND_QUERY,  16'h0000, 16'h0000, 1'b1,
            {1'b0, 1'b0, 8'd0, 1'b0, 8'd0});
    add_row(npt_pkg::KIND_INSERT, 16'h8000, 16'h8000, 1'b1, '0);
    add_row(npt_pkg::KIND_INSERT, 16'h7FFF, 16'h7FFF, 1'b1, '0);
    add_row(npt_pkg::KIND_INSERT, 16'h0000, 16'h0000, 1'b1, '0);
    add_row(npt_pkg::KIND_INSERT, 16'h0000, 16'h0000, 1'b1, '0);
    add_row(npt_pkg::KIND_QUERY,  16'h0000, 16'h0000, 1'b1,
            {1'b0, 1'b1, 8'd2, 1'b1, 8'd2});
    add_row(npt_pkg::KIND_QUERY,  16'h8000, 16'h8000, 1'b1,
            {1'b0, 1'b1, 8'd0, 1'b1, 8'd0});
    add_row(npt_pkg::KIND_QUERY,  16'h7FFF, 16'h7FFF, 1'b1,
            {1'b0, 1'b1, 8'd1, 1'b1, 8'd1});
    add_row(npt_pkg::KIND_QUERY,  16'd11,   16'h0000, 1'b0, '0);
    add_row(npt_pkg::KIND_QUERY,  16'd12,   16'h0000, 1'b1,
            {1'b0, 1'b1, 8'd2, 1'b0, 8'd0});
    add_row(npt_pkg::KIND_QUERY,  16'h8000, 16'h7FFF, 1'b0, '0);
    add_row(npt_pkg::KIND_QUERY,  16'h7FFF, 16'h8000, 1'b0, '0);
    add_row(npt_pkg::KIND_INSERT, 16'hFFFF, 16'h0001, 1'b0, '0);
    add_row(npt_pkg::KIND_QUERY,  16'd8,    16'hFFF8, 1'b0, '0);
    add_row(npt_pkg::KIND_QUERY,  16'h0000, 16'h0001, 1'b0, '0);
    add_row(npt_pkg::KIND_QUERY,  16'hFFFF, 16'd12,   1'b0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (drill_rows[i]) begin
      drive_gap($urandom_range(2, 0));
      send_item(drill_rows[i].kind, drill_rows[i].x, drill_rows[i].y,
                drill_rows[i].typed, drill_rows[i].answer);
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_radius(phase_radius[ph]);
      end
      cx = int'($urandom_range(65535, 0)) - 32768;
      cy = int'($urandom_range(65535, 0)) - 32768;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          drive_gap(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1));
          burst_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(10, 1);
        end
        // hold the receiver off while items keep coming
        if (ph == SQUEEZE_PHASE && n == SQUEEZE_ITEM) squeeze_req = 1'b1;
        pick_item(cx, cy, k, x, y);
        send_item(k, x, y, 1'b0, '0);
        burst_left--;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_nearest_point_table_core: done, clean");
    end else begin
      $display("tb_nearest_point_table_core: done, errors");
    end
    $finish;
  end

endmodule
